[rtl/secnt_pkg.sv]
// Shared types and constants for the skeleton endpoint counter.
// No dependencies; imported by secnt_outq and skeleton_endpoint_counter_5x5.
package secnt_pkg;

	localparam int COORD_W   = 10;
	localparam int CFG_W     = 11;
	localparam int TOTAL_W   = 16;
	localparam int PIX_W     = 8;
	localparam int MIN_SIZE  = 8;
	localparam int MAX_ROWS  = 1024;
	localparam int OUTQ_DEPTH = 4;
	localparam int OQ_PW     = $clog2(OUTQ_DEPTH);

	localparam logic [PIX_W-1:0]   WHITE     = 8'hFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

	localparam logic KIND_ENDPOINT = 1'b0;
	localparam logic KIND_TOTAL    = 1'b1;

	typedef enum logic [2:0] {
		CFG_FRAME_WIDTH    = 3'd0,
		CFG_FRAME_HEIGHT   = 3'd1,
		CFG_REGION_X_START = 3'd2,
		CFG_REGION_X_END   = 3'd3,
		CFG_REGION_Y_START = 3'd4,
		CFG_REGION_Y_END   = 3'd5
	} cfg_index_t;

	// One queue entry per pixel that produced at least one result.
	typedef struct packed {
		logic               ep;
		logic               tot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TOTAL_W-1:0] total;
	} res_entry_t;

endpackage

[rtl/secnt_linebuf.sv]
// Line buffers: one single-bit memory per buffered row, registered read.
// Standalone; instantiated by skeleton_endpoint_counter_5x5.
module secnt_linebuf #(
	parameter int DEPTH = 1024,
	parameter int LINES = 4,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  logic [LINES-1:0] wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic             wr_data,
	output logic [LINES-1:0] rd_data
);

	for (genvar m = 0; m < LINES; m++) begin : g_line
		logic mem [DEPTH];
		logic rd_bit_q;

		always_ff @(posedge clk) begin
			if (wr_en[m]) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_bit_q <= mem[rd_addr];
			end
		end

		assign rd_data[m] = rd_bit_q;
	end

endmodule

[rtl/secnt_cell.sv]
// One window column cell: holds a column of pixels, loads from its neighbor.
// Standalone; chained by skeleton_endpoint_counter_5x5.
module secnt_cell #(
	parameter int SIDE = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            zero,
	input  logic [SIDE-1:0] col_in,
	output logic [SIDE-1:0] col_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= zero ? '0 : col_in;
		end
	end

endmodule

[rtl/secnt_outq.sv]
// Result queue: one entry per pixel, unpacked into one or two transactions.
// Depends on secnt_pkg.
module secnt_outq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  secnt_pkg::res_entry_t            push_data,
	output logic [secnt_pkg::OQ_PW:0]        count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             result_kind,
	output logic [secnt_pkg::COORD_W-1:0]    tip_x,
	output logic [secnt_pkg::COORD_W-1:0]    tip_y,
	output logic [secnt_pkg::TOTAL_W-1:0]    total_count,
	output logic                             last
);
	import secnt_pkg::*;

	res_entry_t         q_mem [OUTQ_DEPTH];
	logic [OQ_PW-1:0]   wr_ptr_q;
	logic [OQ_PW-1:0]   rd_ptr_q;
	logic [OQ_PW:0]     cnt_q;
	logic               phase_q;
	res_entry_t         head;
	logic               is_total;
	logic               pop;

	assign head        = q_mem[rd_ptr_q];
	assign out_valid   = (cnt_q != '0);
	assign is_total    = !head.ep || phase_q;
	assign result_kind = is_total ? KIND_TOTAL : KIND_ENDPOINT;
	assign tip_x       = is_total ? '0 : head.x;
	assign tip_y       = is_total ? '0 : head.y;
	assign total_count = is_total ? head.total : '0;
	assign last        = is_total || !head.tot;
	assign pop         = out_valid && out_ready && last;
	assign count       = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			if (out_valid && out_ready) begin
				phase_q <= !pop;
			end
		end
	end

endmodule

[rtl/skeleton_endpoint_counter_5x5.sv]
// Top level of the skeleton endpoint counter.
// Depends on secnt_pkg, secnt_linebuf, secnt_cell and secnt_outq.
//
// Usage:
//   Pixels enter on in_valid/in_ready/pixel_value in raster order, one per
//   transaction; 255 is white. Results leave on out_valid/out_ready: an
//   endpoint (result_kind 0, tip_x, tip_y) or, after the last pixel of a
//   frame, the saturating frame total (result_kind 1, total_count). last
//   marks the final result caused by one pixel.
//   Registers are written on cfg_valid/cfg_index/cfg_data; cfg_ready is
//   always high. Write them only while the block is idle.
// Timing:
//   One pixel per cycle sustained while out_ready stays high. A result is
//   offered once its pixel has passed stage 1 and stage 2 and been queued.
//   A pixel yielding an endpoint and a frame total needs two transactions. The
//   rate rests on one line buffer read and write per pixel and a four-entry queue.
// Reset and stalls:
//   After reset the line buffers are cleared, one column per cycle, up to
//   address MAX_WIDTH-1; in_ready stays low meanwhile. When the receiver stalls
//   the queue fills and in_ready drops once in-flight pixels could overflow it.
module skeleton_endpoint_counter_5x5 #(
	parameter int MAX_WIDTH     = 1024,
	parameter int WINDOW_RADIUS = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [secnt_pkg::PIX_W-1:0]      pixel_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             result_kind,
	output logic [secnt_pkg::COORD_W-1:0]    tip_x,
	output logic [secnt_pkg::COORD_W-1:0]    tip_y,
	output logic [secnt_pkg::TOTAL_W-1:0]    total_count,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [secnt_pkg::CFG_W-1:0]      cfg_data
);
	import secnt_pkg::*;

	localparam int SIDE  = 2 * WINDOW_RADIUS + 1;
	localparam int LINES = 2 * WINDOW_RADIUS;
	localparam int SW    = $clog2(LINES);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int CW    = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
	localparam int CBIT  = WINDOW_RADIUS * SIDE + WINDOW_RADIUS;
	localparam int NWIN  = SIDE * SIDE;

	// Configuration registers
	logic [CFG_W-1:0]   cfg_frame_width_q;
	logic [CFG_W-1:0]   cfg_frame_height_q;
	logic [COORD_W-1:0] cfg_x_start_q;
	logic [CFG_W-1:0]   cfg_x_end_q;
	logic [COORD_W-1:0] cfg_y_start_q;
	logic [CFG_W-1:0]   cfg_y_end_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_frame_width_q  <= 11'd640;
			cfg_frame_height_q <= 11'd480;
			cfg_x_start_q      <= 10'd160;
			cfg_x_end_q        <= 11'd480;
			cfg_y_start_q      <= 10'd120;
			cfg_y_end_q        <= 11'd360;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:    cfg_frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT:   cfg_frame_height_q <= cfg_data;
				CFG_REGION_X_START: cfg_x_start_q      <= cfg_data[COORD_W-1:0];
				CFG_REGION_X_END:   cfg_x_end_q        <= cfg_data;
				CFG_REGION_Y_START: cfg_y_start_q      <= cfg_data[COORD_W-1:0];
				CFG_REGION_Y_END:   cfg_y_end_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped frame size
	logic [CW-1:0]    fw;
	logic [CW-1:0]    w;
	logic [CFG_W-1:0] h;

	always_comb begin
		fw = CW'(cfg_frame_width_q);
		if (fw < CW'(MIN_SIZE)) begin
			w = CW'(MIN_SIZE);
		end else if (fw > CW'(MAX_WIDTH)) begin
			w = CW'(MAX_WIDTH);
		end else begin
			w = fw;
		end
		if (cfg_frame_height_q < CFG_W'(MIN_SIZE)) begin
			h = CFG_W'(MIN_SIZE);
		end else if (cfg_frame_height_q > CFG_W'(MAX_ROWS)) begin
			h = CFG_W'(MAX_ROWS);
		end else begin
			h = cfg_frame_height_q;
		end
	end

	// Line buffer clearing after reset
	logic          clr_q;
	logic [XW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == XW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Raster position
	logic [XW-1:0]      col_q;
	logic [COORD_W-1:0] row_q;
	logic [SW-1:0]      slot_q;
	logic               acc;
	logic               white;
	logic               last_col;
	logic               last_row;

	assign acc      = in_valid && in_ready;
	assign white    = (pixel_value == WHITE);
	assign last_col = (CW'(col_q) + CW'(1) >= w);
	assign last_row = (CFG_W'(row_q) + CFG_W'(1) >= h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					slot_q <= (slot_q == SW'(LINES - 1)) ? '0 : slot_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Line buffers
	logic [LINES-1:0] lb_wr_en;
	logic [LINES-1:0] rd_s1;

	for (genvar m = 0; m < LINES; m++) begin : g_wen
		assign lb_wr_en[m] = clr_q || (acc && slot_q == SW'(m));
	end

	secnt_linebuf #(
		.DEPTH (MAX_WIDTH),
		.LINES (LINES),
		.AW    (XW)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.wr_en   (lb_wr_en),
		.wr_addr (clr_q ? clr_addr_q : col_q),
		.wr_data (!clr_q && white),
		.rd_data (rd_s1)
	);

	// Stage 1: pixel attributes alongside line buffer read data
	logic               v_s1;
	logic               white_s1;
	logic [XW-1:0]      x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [SW-1:0]      slot_s1;
	logic               fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			white_s1 <= white;
			x_s1     <= col_q;
			y_s1     <= row_q;
			slot_s1  <= slot_q;
			fe_s1    <= last_col && last_row;
		end
	end

	// New window column: buffered rows oldest first, then the incoming pixel
	logic [SIDE-1:0] newcol;

	always_comb begin
		int k;
		int sel;
		newcol = '0;
		for (int r = 0; r < LINES; r++) begin
			k = LINES - r;
			if (int'(slot_s1) >= k) begin
				sel = int'(slot_s1) - k;
			end else begin
				sel = int'(slot_s1) + LINES - k;
			end
			if (int'(y_s1) >= k) begin
				newcol[r] = rd_s1[sel[SW-1:0]];
			end
		end
		newcol[LINES] = white_s1;
	end

	// Window cell chain; column 0 is the newest
	logic [SIDE-1:0] col_w [SIDE];

	for (genvar c = 0; c < SIDE; c++) begin : g_cell
		secnt_cell #(
			.SIDE (SIDE)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (v_s1),
			.zero   ((c != 0) && (x_s1 == '0)),
			.col_in ((c == 0) ? newcol : col_w[(c == 0) ? 0 : c - 1]),
			.col_q  (col_w[c])
		);
	end

	// Centre candidate check
	logic [XW-1:0]      cx;
	logic [COORD_W-1:0] cy;
	logic               cand;

	assign cx   = x_s1 - XW'(WINDOW_RADIUS);
	assign cy   = y_s1 - COORD_W'(WINDOW_RADIUS);
	assign cand = (x_s1 >= XW'(WINDOW_RADIUS)) && (y_s1 >= COORD_W'(WINDOW_RADIUS))
		&& (CW'(cx) >= CW'(cfg_x_start_q)) && (CW'(cx) < CW'(cfg_x_end_q))
		&& (CFG_W'(cy) >= CFG_W'(cfg_y_start_q)) && (CFG_W'(cy) < cfg_y_end_q);

	// Stage 2: window holds this pixel's neighborhood
	logic               v_s2;
	logic               cand_s2;
	logic [COORD_W-1:0] cx_s2;
	logic [COORD_W-1:0] cy_s2;
	logic               fe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			cand_s2 <= cand;
			cx_s2   <= COORD_W'(cx);
			cy_s2   <= cy;
			fe_s2   <= fe_s1;
		end
	end

	logic [NWIN-1:0] win;
	logic [NWIN-1:0] others;
	logic            ep;

	for (genvar r = 0; r < SIDE; r++) begin : g_row
		for (genvar c = 0; c < SIDE; c++) begin : g_col
			assign win[r * SIDE + c] = col_w[c][r];
		end
	end

	always_comb begin
		others       = win;
		others[CBIT] = 1'b0;
	end

	assign ep = v_s2 && cand_s2 && win[CBIT] && (others != '0)
		&& ((others & (others - 1'b1)) == '0);

	// Frame total
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_next;

	assign total_next = (ep && total_q != TOTAL_MAX) ? total_q + 1'b1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (v_s2) begin
			total_q <= fe_s2 ? '0 : total_next;
		end
	end

	// Result queue
	res_entry_t       entry;
	logic [OQ_PW:0]   oq_cnt;
	logic [OQ_PW+1:0] rsv;

	always_comb begin
		entry.ep    = ep;
		entry.tot   = fe_s2;
		entry.x     = cx_s2;
		entry.y     = cy_s2;
		entry.total = total_next;
	end

	secnt_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (v_s2 && (ep || fe_s2)),
		.push_data   (entry),
		.count       (oq_cnt),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.tip_x       (tip_x),
		.tip_y       (tip_y),
		.total_count (total_count),
		.last        (last)
	);

	assign rsv      = (OQ_PW + 2)'(oq_cnt) + (OQ_PW + 2)'(v_s1) + (OQ_PW + 2)'(v_s2);
	assign in_ready = !clr_q && (rsv < (OQ_PW + 2)'(OUTQ_DEPTH));

endmodule

[dv/tip_check_pkg.sv]
`timescale 1ns / 1ps
// Pixel-level predictor and result checker for the skeleton endpoint counter.
// Depends on secnt_pkg for widths, result kinds and register indexes.
package tip_check_pkg;
	import secnt_pkg::*;

	localparam int LINE_LEN = 1024;
	localparam int WIN_R    = 2;
	localparam int WIN_SIDE = 2 * WIN_R + 1;
	localparam int LINES    = 2 * WIN_R;
	localparam int CENTER   = WIN_R * WIN_SIDE + WIN_R;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} tip_report_t;

	class tip_tracker;
		bit                             line_bits[LINES][LINE_LEN];
		bit [WIN_SIDE*WIN_SIDE-1:0]     window;
		int unsigned                    col_next;
		int unsigned                    row_next;
		int unsigned                    tally;
		int unsigned                    width_reg;
		int unsigned                    height_reg;
		int unsigned                    x_lo;
		int unsigned                    x_hi;
		int unsigned                    y_lo;
		int unsigned                    y_hi;
		tip_report_t                    reports[$];
		int                             errors;

		function new();
			width_reg  = 640;
			height_reg = 480;
			x_lo       = 160;
			x_hi       = 480;
			y_lo       = 120;
			y_hi       = 360;
		endfunction

		function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_FRAME_WIDTH:    width_reg  = data;
				CFG_FRAME_HEIGHT:   height_reg = data;
				CFG_REGION_X_START: x_lo       = data[COORD_W-1:0];
				CFG_REGION_X_END:   x_hi       = data;
				CFG_REGION_Y_START: y_lo       = data[COORD_W-1:0];
				CFG_REGION_Y_END:   y_hi       = data;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_size(int unsigned v, int unsigned hi);
			if (v < MIN_SIZE)
				return MIN_SIZE;
			return (v > hi) ? hi : v;
		endfunction

		function void take_pixel(logic [PIX_W-1:0] value);
			int unsigned                w, h, x, y, cx, cy;
			bit                         white, hit, frame_end;
			bit [WIN_SIDE*WIN_SIDE-1:0] fresh, newest_col, others;
			tip_report_t                rep;
			w = clamp_size(width_reg, LINE_LEN);
			h = clamp_size(height_reg, MAX_ROWS);
			x = (col_next >= LINE_LEN) ? LINE_LEN - 1 : col_next;
			y = row_next;
			white = (value == WHITE);
			fresh = '0;
			newest_col = '0;
			for (int r = 0; r < WIN_SIDE; r++) begin
				newest_col[r*WIN_SIDE] = 1'b1;
				if (r == LINES)
					fresh[r*WIN_SIDE] = white;
				else if (y >= LINES - r)
					fresh[r*WIN_SIDE] = line_bits[(y - (LINES - r)) % LINES][x];
			end
			if (x == 0)
				window = '0;
			window = ((window << 1) & ~newest_col) | fresh;
			line_bits[y % LINES][x] = white;

			hit = 1'b0;
			cx = 0;
			cy = 0;
			if (x >= WIN_R && y >= WIN_R) begin
				cx = x - WIN_R;
				cy = y - WIN_R;
				others = window;
				others[CENTER] = 1'b0;
				if (cx >= x_lo && cx < x_hi && cy >= y_lo && cy < y_hi &&
				    window[CENTER] && $countones(others) == 1) begin
					hit = 1'b1;
					if (tally < TOTAL_MAX)
						tally++;
				end
			end

			frame_end = 1'b0;
			if (x + 1 >= w) begin
				col_next = 0;
				if (y + 1 >= h) begin
					frame_end = 1'b1;
					row_next = 0;
				end else begin
					row_next = y + 1;
				end
			end else begin
				col_next = x + 1;
			end

			if (hit) begin
				rep.kind  = KIND_ENDPOINT;
				rep.x     = COORD_W'(cx);
				rep.y     = COORD_W'(cy);
				rep.total = '0;
				rep.last  = !frame_end;
				reports = {reports, rep};
			end
			if (frame_end) begin
				rep.kind  = KIND_TOTAL;
				rep.x     = '0;
				rep.y     = '0;
				rep.total = TOTAL_W'(tally);
				rep.last  = 1'b1;
				reports = {reports, rep};
				tally = 0;
			end
		endfunction

		function void check_field(string name, int unsigned want, logic [31:0] seen);
			if (seen !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void match_report(tip_report_t got);
			tip_report_t want;
			if (reports.size() == 0) begin
				$error("result with nothing pending: kind %0d x %0d y %0d total %0d last %0d",
				       got.kind, got.x, got.y, got.total, got.last);
				errors++;
				return;
			end
			want = reports.pop_front();
			check_field("result_kind", want.kind, got.kind);
			check_field("tip_x", want.x, got.x);
			check_field("tip_y", want.y, got.y);
			check_field("total_count", want.total, got.total);
			check_field("last", want.last, got.last);
		endfunction

		function int pending();
			return reports.size();
		endfunction
	endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench for skeleton_endpoint_counter_5x5: painted frames in,
// endpoint and frame-total transactions checked. Depends on secnt_pkg and tip_check_pkg.
module tb_top;
	import secnt_pkg::*;
	import tip_check_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 150;

	typedef enum int {PAINT_BLANK, PAINT_PAIRS, PAINT_SEGMENTS, PAINT_SPECKLE,
	                  PAINT_NOISE, PAINT_WHITE} paint_t;
	typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} stall_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [PIX_W-1:0]   pixel_value;
	logic               out_valid;
	logic               out_ready;
	logic               result_kind;
	logic [COORD_W-1:0] tip_x;
	logic [COORD_W-1:0] tip_y;
	logic [TOTAL_W-1:0] total_count;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	tip_tracker         tips;
	tip_report_t        seen_report;
	logic [PIX_W-1:0]   canvas[];
	int                 burst_left;
	int                 idle_cycles;
	bit                 no_idle;
	bit                 hold_req;

	skeleton_endpoint_counter_5x5 u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.tip_x       (tip_x),
		.tip_y       (tip_y),
		.total_count (total_count),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			seen_report.kind  = result_kind;
			seen_report.x     = tip_x;
			seen_report.y     = tip_y;
			seen_report.total = total_count;
			seen_report.last  = last;
			tips.match_report(seen_report);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : receiver
		stall_t pattern;
		int     pattern_left;
		int     period;
		int     phase;
		out_ready = 1'b0;
		pattern = READY_ALWAYS;
		pattern_left = 0;
		period = 2;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (pattern_left == 0) begin
					pattern = stall_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(32, 400);
					period = $urandom_range(2, 9);
				end
				pattern_left--;
				phase++;
				if (no_idle)
					out_ready <= 1'b1;
				else case (pattern)
					READY_ALWAYS:   out_ready <= 1'b1;
					READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
					READY_PERIODIC: out_ready <= (phase % period) != 0;
					default:        out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic offer_pixel(logic [PIX_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			if (no_idle)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(5, 20);
			else
				gap = $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = no_idle ? 1000 : $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		pixel_value <= value;
		do @(posedge clk); while (!in_ready);
		tips.take_pixel(value);
		burst_left--;
	endtask

	task automatic send_span(int first, int count);
		for (int i = first; i < first + count; i++)
			offer_pixel(canvas[i]);
	endtask

	// drop valid and let in-flight pixels drain before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (tips.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(cfg_index_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		tips.set_reg(idx, CFG_W'(value));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(int unsigned fw, int unsigned fh, int unsigned x0,
	                         int unsigned x1, int unsigned y0, int unsigned y1);
		settle();
		write_reg(CFG_FRAME_WIDTH, fw);
		write_reg(CFG_FRAME_HEIGHT, fh);
		write_reg(CFG_REGION_X_START, x0);
		write_reg(CFG_REGION_X_END, x1);
		write_reg(CFG_REGION_Y_START, y0);
		write_reg(CFG_REGION_Y_END, y1);
	endtask

	task automatic paint(paint_t style, int w, int h);
		int sx, sy, dx, dy, len;
		canvas = new[w * h];
		for (int i = 0; i < w * h; i++)
			canvas[i] = ($urandom_range(0, 4) == 0) ? PIX_W'($urandom_range(0, 254)) : '0;
		case (style)
			PAINT_PAIRS:
				for (int y = 0; y < h; y++)
					for (int x = 0; x < w; x++)
						if (y % 3 == 0 && x % 4 < 2)
							canvas[y*w + x] = WHITE;
			PAINT_WHITE:
				for (int i = 0; i < w * h; i++)
					canvas[i] = WHITE;
			PAINT_SPECKLE:
				for (int i = 0; i < w * h; i++)
					if ($urandom_range(0, 15) == 0)
						canvas[i] = WHITE;
			PAINT_NOISE:
				for (int i = 0; i < w * h; i++)
					canvas[i] = ($urandom_range(0, 5) == 0) ? WHITE : PIX_W'($urandom_range(0, 255));
			PAINT_SEGMENTS:
				repeat (w * h / 24 + 1) begin
					sx = $urandom_range(0, w - 1);
					sy = $urandom_range(0, h - 1);
					do begin
						dx = $urandom_range(0, 2) - 1;
						dy = $urandom_range(0, 2) - 1;
					end while (dx == 0 && dy == 0);
					len = $urandom_range(1, 6);
					for (int k = 0; k < len; k++) begin
						if (sx >= 0 && sx < w && sy >= 0 && sy < h)
							canvas[sy*w + sx] = WHITE;
						sx += dx;
						sy += dy;
					end
				end
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int     w, h, wr, hr, x0, x1, y0, y1, split, random_sent, pick;
		paint_t style;
		tips = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		burst_left = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!in_ready);

		// corner pair, inner vertical pair, lone corners, near-white blacks
		set_frame(8, 8, 0, 8, 0, 8);
		paint(PAINT_BLANK, 8, 8);
		canvas[0] = WHITE;
		canvas[1] = WHITE;
		canvas[2*8 + 5] = WHITE;
		canvas[3*8 + 5] = WHITE;
		canvas[7*8] = WHITE;
		canvas[63] = WHITE;
		canvas[6] = 8'hFE;
		canvas[7] = 8'h7F;
		canvas[8] = 8'h80;
		send_span(0, 64);

		// clamped sizes, inverted and empty region
		set_frame(3, 5, 6, 2, 4, 0);
		send_span(0, 64);

		// white frame, then pairs: stale line data must not leak; receiver holds off
		set_frame(8, 8, 0, 1024, 0, 2047);
		paint(PAINT_WHITE, 8, 8);
		send_span(0, 64);
		set_frame(16, 12, 0, 1024, 0, 1024);
		paint(PAINT_PAIRS, 16, 12);
		no_idle = 1'b1;
		hold_req = 1'b1;
		send_span(0, 192);
		no_idle = 1'b0;

		// height and width shrunk mid-frame
		set_frame(16, 2047, 0, 1024, 0, 1024);
		paint(PAINT_SPECKLE, 16, 12);
		send_span(0, 160);
		settle();
		write_reg(CFG_FRAME_HEIGHT, 8);
		send_span(160, 16);
		set_frame(16, 8, 0, 1024, 0, 1024);
		send_span(0, 92);
		settle();
		write_reg(CFG_FRAME_WIDTH, 8);
		send_span(92, 17);

		// region starting past the frame
		set_frame(8, 8, 1023, 2047, 1023, 1024);
		paint(PAINT_SEGMENTS, 8, 8);
		send_span(0, 64);

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			w = $urandom_range(8, 20);
			h = $urandom_range(8, 12);
			wr = w;
			hr = h;
			if ($urandom_range(0, 7) == 0) begin
				wr = $urandom_range(0, 7);
				w = 8;
			end
			if ($urandom_range(0, 7) == 0) begin
				hr = $urandom_range(0, 7);
				h = 8;
			end
			if ($urandom_range(0, 2) == 0) begin
				x0 = $urandom_range(0, w);
				x1 = $urandom_range(0, w + 1);
				y0 = $urandom_range(0, h);
				y1 = $urandom_range(0, h + 1);
			end else begin
				x0 = 0;
				x1 = 1024;
				y0 = 0;
				y1 = 1024;
			end
			pick = $urandom_range(0, 9);
			if (pick < 5)
				style = PAINT_SEGMENTS;
			else if (pick < 7)
				style = PAINT_SPECKLE;
			else if (pick < 8)
				style = PAINT_PAIRS;
			else
				style = PAINT_NOISE;
			set_frame(wr, hr, x0, x1, y0, y1);
			paint(style, w, h);
			if ($urandom_range(0, 3) == 0) begin
				split = $urandom_range(1, w * h - 1);
				send_span(0, split);
				settle();
				send_span(split, w * h - split);
			end else begin
				send_span(0, w * h);
			end
			random_sent += w * h;
		end

		settle();
		if (tips.errors == 0 && tips.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
